### hw/rtl/cdw_pkg.sv
// ----------------------------------------------------------------------------
// cdw_pkg: shared types and constants for the chain double-well energy block
// Item layouts, coefficient selects, register indexes, sequencer states and
// the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package cdw_pkg;

  // Input item layout, first field in the most significant bits.
  typedef struct packed {
    logic               operation;
    logic [9:0]         site;
    logic [2:0]         coef_select;
    logic signed [23:0] coef_value;
    logic signed [19:0] bend;
    logic signed [19:0] twist;
  } cdw_in_t;

  // Result item layout.
  typedef struct packed {
    logic signed [47:0] total_energy;
    logic               order_error;
  } cdw_out_t;

  // One site's six coefficients as read from the memories.
  typedef struct packed {
    logic signed [23:0] q;
    logic signed [23:0] m;
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] c;
    logic signed [23:0] d;
  } cdw_coef_t;

  // Command from the control FSM to the arithmetic engine.
  typedef struct packed {
    logic               start;
    logic               bond_en;
    logic               last;
    logic signed [19:0] k;
    logic signed [19:0] t;
    cdw_coef_t          coef;
  } cdw_cmd_t;

  // Status from the engine back to the control FSM.
  typedef struct packed {
    logic               done;
    logic signed [47:0] total;
  } cdw_sts_t;

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Coefficient selects.
  localparam logic [2:0] COEF_Q = 3'd0;
  localparam logic [2:0] COEF_M = 3'd1;
  localparam logic [2:0] COEF_A = 3'd2;
  localparam logic [2:0] COEF_B = 3'd3;
  localparam logic [2:0] COEF_C = 3'd4;
  localparam logic [2:0] COEF_D = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHAIN_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_NEIGHBOUR_SHIFT = 2'd1;
  localparam logic [1:0] CFG_ONSITE_SCALE    = 2'd2;

  // Fixed-point constants in Q.16.
  localparam logic signed [63:0] ONE_Q = 64'sd65536;
  localparam logic signed [63:0] TWO_Q = 64'sd131072;

  // Saturation bounds of the 48-bit results.
  localparam logic signed [63:0] SAT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] SAT_MIN = -64'sd140737488355328;

  // Control FSM states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_RUN,
    CS_EMIT
  } cdw_state_t;

  // Engine sequencer steps; each multiply step has an issue phase and a use phase.
  typedef enum logic [4:0] {
    S_IDLE,
    S_BOND,
    S_KK,
    S_MM,
    S_TT,
    S_DD,
    S_QH,
    S_QL,
    S_KD,
    S_UC,
    S_VH,
    S_VL,
    S_KB,
    S_UA,
    S_WH,
    S_WL,
    S_SUM,
    S_EBH,
    S_EBL,
    S_EOH,
    S_EOL
  } cdw_step_t;

  // Clamp a wide signed value into the 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [47:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[47:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[47:0];
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/cdw_coef_mem.sv
// ----------------------------------------------------------------------------
// cdw_coef_mem: per-site coefficient storage
// Six synchronous memories, one per coefficient, written one entry at a time
// and read all together with a registered read port.
// ----------------------------------------------------------------------------
module cdw_coef_mem #(
  parameter int MAX_SITES = 1024
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [2:0]                  wr_sel,
  input  logic [$clog2(MAX_SITES)-1:0] wr_addr,
  input  logic signed [23:0]          wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_SITES)-1:0] rd_addr,
  output cdw_pkg::cdw_coef_t          rd_data
);
  import cdw_pkg::*;

  logic signed [23:0] q_mem [MAX_SITES];
  logic signed [23:0] m_mem [MAX_SITES];
  logic signed [23:0] a_mem [MAX_SITES];
  logic signed [23:0] b_mem [MAX_SITES];
  logic signed [23:0] c_mem [MAX_SITES];
  logic signed [23:0] d_mem [MAX_SITES];

  cdw_coef_t rd_data_r;

  // Write one coefficient; unused selects write nothing.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_sel)
        COEF_Q:  q_mem[wr_addr] <= wr_data;
        COEF_M:  m_mem[wr_addr] <= wr_data;
        COEF_A:  a_mem[wr_addr] <= wr_data;
        COEF_B:  b_mem[wr_addr] <= wr_data;
        COEF_C:  c_mem[wr_addr] <= wr_data;
        COEF_D:  d_mem[wr_addr] <= wr_data;
        default: ;
      endcase
    end
  end

  // Registered read of all six coefficients of one site.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.q <= q_mem[rd_addr];
      rd_data_r.m <= m_mem[rd_addr];
      rd_data_r.a <= a_mem[rd_addr];
      rd_data_r.b <= b_mem[rd_addr];
      rd_data_r.c <= c_mem[rd_addr];
      rd_data_r.d <= d_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/cdw_engine.sv
// ----------------------------------------------------------------------------
// cdw_engine: shared-multiplier arithmetic sequencer
// Computes one site's on-site term and bond product with a single registered
// 33x33 multiplier, keeps the chain sums and forms the scaled total.
// ----------------------------------------------------------------------------
module cdw_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  cdw_pkg::cdw_cmd_t  cmd,
  input  logic signed [23:0] neighbour_shift,
  input  logic signed [23:0] onsite_scale,
  output cdw_pkg::cdw_sts_t  sts
);
  import cdw_pkg::*;

  cdw_step_t step_r, step_nxt;
  logic      phase_r, phase_nxt;
  logic      finish;
  logic      done_r;

  // Captured sample and coefficients.
  logic signed [19:0] k_r, t_r;
  cdw_coef_t          coef_r;
  logic               last_r;

  // Intermediate results.
  logic signed [23:0] k2_r, t2_r;
  logic signed [31:0] m2_r, u_r;
  logic signed [47:0] dd_r, v_r;
  logic signed [63:0] tmp_r, quart_r, twist_r, tilt_r, e1_r;
  logic signed [65:0] p_r;

  // Chain accumulators.
  logic signed [19:0] prev_r;
  logic signed [47:0] bond_r, onsite_r, total_r;

  logic signed [32:0] opa, opb;
  logic signed [63:0] psh;
  logic signed [32:0] diff;
  logic signed [32:0] y1;
  logic signed [47:0] site_term;

  // Successor of a multiply step.
  function automatic cdw_step_t succ(input cdw_step_t s);
    cdw_step_t n;
    case (s)
      S_BOND:  n = S_KK;
      S_KK:    n = S_MM;
      S_MM:    n = S_TT;
      S_TT:    n = S_DD;
      S_DD:    n = S_QH;
      S_QH:    n = S_QL;
      S_QL:    n = S_KD;
      S_KD:    n = S_UC;
      S_UC:    n = S_VH;
      S_VH:    n = S_VL;
      S_VL:    n = S_KB;
      S_KB:    n = S_UA;
      S_UA:    n = S_WH;
      S_WH:    n = S_WL;
      S_WL:    n = S_SUM;
      S_EBH:   n = S_EBL;
      S_EBL:   n = S_EOH;
      S_EOH:   n = S_EOL;
      default: n = S_IDLE;
    endcase
    return n;
  endfunction

  assign psh       = 64'(p_r >>> 16);
  assign diff      = 33'(k2_r) - 33'(m2_r);
  assign y1        = 33'(TWO_Q + 64'(neighbour_shift));
  assign site_term = sat48(64'(k2_r) + 64'(k2_r) + quart_r + twist_r - tilt_r);

  // Next step.
  always_comb begin
    step_nxt  = step_r;
    phase_nxt = 1'b0;
    finish    = 1'b0;
    case (step_r)
      S_IDLE: begin
        if (cmd.start) begin
          step_nxt = cmd.bond_en ? S_BOND : S_KK;
        end
      end
      S_SUM: begin
        step_nxt = last_r ? S_EBH : S_IDLE;
        finish   = !last_r;
      end
      default: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          step_nxt = succ(step_r);
          finish   = (step_r == S_EOL);
        end
      end
    endcase
  end

  // Multiplier operands for each step.
  always_comb begin
    opa = '0;
    opb = '0;
    case (step_r)
      S_BOND: begin opa = 33'(prev_r);              opb = 33'(k_r);          end
      S_KK:   begin opa = 33'(k_r);                 opb = 33'(k_r);          end
      S_MM:   begin opa = 33'(coef_r.m);            opb = 33'(coef_r.m);     end
      S_TT:   begin opa = 33'(t_r);                 opb = 33'(t_r);          end
      S_DD:   begin opa = diff;                     opb = diff;              end
      S_QH:   begin opa = 33'(dd_r >>> 16);         opb = 33'(coef_r.q);     end
      S_QL:   begin opa = $signed({17'b0, dd_r[15:0]}); opb = 33'(coef_r.q); end
      S_KD:   begin opa = 33'(k2_r);                opb = 33'(coef_r.d);     end
      S_UC:   begin opa = 33'(u_r);                 opb = 33'(coef_r.c);     end
      S_VH:   begin opa = 33'(v_r >>> 16);          opb = 33'(t2_r);         end
      S_VL:   begin opa = $signed({17'b0, v_r[15:0]}); opb = 33'(t2_r);      end
      S_KB:   begin opa = 33'(k2_r);                opb = 33'(coef_r.b);     end
      S_UA:   begin opa = 33'(u_r);                 opb = 33'(coef_r.a);     end
      S_WH:   begin opa = 33'(v_r >>> 16);          opb = 33'(t_r);          end
      S_WL:   begin opa = $signed({17'b0, v_r[15:0]}); opb = 33'(t_r);       end
      S_EBH:  begin opa = 33'(bond_r >>> 16);       opb = y1;                end
      S_EBL:  begin opa = $signed({17'b0, bond_r[15:0]}); opb = y1;          end
      S_EOH:  begin opa = 33'(onsite_r >>> 16);     opb = 33'(onsite_scale); end
      S_EOL:  begin opa = $signed({17'b0, onsite_r[15:0]}); opb = 33'(onsite_scale); end
      default: ;
    endcase
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= S_IDLE;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      done_r  <= finish;
    end
  end

  // Product register after the shared multiplier.
  always_ff @(posedge clk) begin
    p_r <= opa * opb;
  end

  // Capture the command when a site starts.
  always_ff @(posedge clk) begin
    if (step_r == S_IDLE && cmd.start) begin
      k_r       <= cmd.k;
      t_r       <= cmd.t;
      coef_r    <= cmd.coef;
      last_r    <= cmd.last;
    end
  end

  // Use each product in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (phase_r) begin
      case (step_r)
        S_KK:    k2_r    <= psh[23:0];
        S_MM:    m2_r    <= psh[31:0];
        S_TT:    t2_r    <= psh[23:0];
        S_DD:    dd_r    <= psh[47:0];
        S_QH:    tmp_r   <= 64'(p_r);
        S_QL:    quart_r <= tmp_r + psh;
        S_KD:    u_r     <= 32'(psh + ONE_Q);
        S_UC:    v_r     <= psh[47:0];
        S_VH:    tmp_r   <= 64'(p_r);
        S_VL:    twist_r <= (tmp_r + psh) >>> 1;
        S_KB:    u_r     <= 32'(psh + ONE_Q);
        S_UA:    v_r     <= psh[47:0];
        S_WH:    tmp_r   <= 64'(p_r);
        S_WL:    tilt_r  <= tmp_r + psh;
        S_EBH:   tmp_r   <= 64'(p_r);
        S_EBL:   e1_r    <= tmp_r + psh;
        S_EOH:   tmp_r   <= 64'(p_r);
        S_EOL:   total_r <= sat48(tmp_r + psh - e1_r);
        default: ;
      endcase
    end
  end

  // Chain accumulators; cleared after the total has been formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      bond_r   <= '0;
      onsite_r <= '0;
    end else if (step_r == S_BOND && phase_r) begin
      bond_r <= sat48(64'(bond_r) + psh + psh);
    end else if (step_r == S_SUM) begin
      onsite_r <= sat48(64'(onsite_r) + 64'(site_term));
      prev_r   <= k_r;
    end else if (step_r == S_EOL && phase_r) begin
      prev_r   <= '0;
      bond_r   <= '0;
      onsite_r <= '0;
    end
  end

  assign sts.done  = done_r;
  assign sts.total = total_r;

endmodule

### hw/rtl/chain_double_well_energy.sv
// ----------------------------------------------------------------------------
// chain_double_well_energy: total double-well energy of a chain
// Loads per-site coefficients, accumulates on-site and bond energy over the
// samples of a chain and delivers the saturated, scaled total.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of cdw_in_t items. A write item (operation 0)
//           stores one coefficient; the block stays ready for the next item. A sample item
//           (operation 1) carries the bend and twist of one site, in order.
//   out_* : valid/ready channel of cdw_out_t items, one per finished chain.
//   cfg_* : plain register write port (chain length, mu, alpha).
// Sequence: a sample goes through one memory read, fifteen products on the
//   shared 33x33 multiplier and one accumulate before the next ready; the first
//   sample of a chain skips the bond product. The last sample of a chain adds
//   the final scaling and a load of the result register.
// Reset clears the accumulators, the site counter and the registers to their
//   defaults; the coefficient memories keep whatever they held.
// A stalled receiver holds the result in the output register; the block keeps
//   taking items and only waits when a second total is ready before the first
//   has been taken.
// ----------------------------------------------------------------------------
module chain_double_well_energy #(
  parameter int MAX_SITES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdw_pkg::cdw_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdw_pkg::cdw_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_wdata
);
  import cdw_pkg::*;

  localparam int AW = $clog2(MAX_SITES);

  cdw_state_t state_r, state_nxt;

  logic [10:0]        chain_length_r;
  logic signed [23:0] neighbour_shift_r, onsite_scale_r;

  logic [10:0] expected_r;
  logic        fault_r;
  logic        last_r, bond_en_r, range_r, chain_fault_r;
  logic signed [19:0] k_r, t_r;

  logic        out_valid_r;
  cdw_out_t    out_data_r;

  logic              accept, sample_acc, write_acc, emit_load;
  logic [AW+9:0]     site_ext;
  logic [AW-1:0]     addr;
  logic              in_range;
  logic [31:0]       len_eff;
  logic              is_last;
  cdw_coef_t         mem_rd;
  cdw_cmd_t          eng_cmd;
  cdw_sts_t          eng_sts;

  // Input decode.
  assign accept     = in_valid && in_ready;
  assign sample_acc = accept && (in_data.operation == OP_SAMPLE);
  assign write_acc  = accept && (in_data.operation == OP_WRITE);
  assign site_ext   = {AW'(0), in_data.site};
  assign addr       = site_ext[AW-1:0];
  assign in_range   = (32'(in_data.site) < MAX_SITES);

  // Effective chain length, clamped to one site and to the memory depth.
  always_comb begin
    if (chain_length_r == '0) begin
      len_eff = 32'd1;
    end else if (32'(chain_length_r) > MAX_SITES) begin
      len_eff = 32'(MAX_SITES);
    end else begin
      len_eff = 32'(chain_length_r);
    end
  end
  assign is_last = (32'(expected_r) + 32'd1 >= len_eff);

  cdw_coef_mem #(
    .MAX_SITES(MAX_SITES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (write_acc && in_range),
    .wr_sel  (in_data.coef_select),
    .wr_addr (addr),
    .wr_data (in_data.coef_value),
    .rd_en   (sample_acc),
    .rd_addr (addr),
    .rd_data (mem_rd)
  );

  // Command to the engine; sites past the memory see zero coefficients.
  always_comb begin
    eng_cmd.start   = (state_r == CS_READ);
    eng_cmd.bond_en = bond_en_r;
    eng_cmd.last    = last_r;
    eng_cmd.k       = k_r;
    eng_cmd.t       = t_r;
    eng_cmd.coef    = range_r ? mem_rd : '0;
  end

  cdw_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (eng_cmd),
    .neighbour_shift (neighbour_shift_r),
    .onsite_scale    (onsite_scale_r),
    .sts             (eng_sts)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (sample_acc) state_nxt = CS_READ;
      CS_READ: state_nxt = CS_RUN;
      CS_RUN: begin
        if (eng_sts.done) begin
          state_nxt = last_r ? CS_EMIT : CS_IDLE;
        end
      end
      CS_EMIT: if (!out_valid_r || out_ready) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      CS_IDLE: in_ready  = 1'b1;
      CS_EMIT: emit_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_length_r    <= 11'd1024;
      neighbour_shift_r <= '0;
      onsite_scale_r    <= 24'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHAIN_LENGTH:    chain_length_r    <= cfg_wdata[10:0];
        CFG_NEIGHBOUR_SHIFT: neighbour_shift_r <= $signed(cfg_wdata);
        CFG_ONSITE_SCALE:    onsite_scale_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Site position and order tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      fault_r    <= 1'b0;
    end else if (sample_acc) begin
      if (is_last) begin
        expected_r <= '0;
        fault_r    <= 1'b0;
      end else begin
        expected_r <= expected_r + 11'd1;
        fault_r    <= fault_r || ({1'b0, in_data.site} != expected_r);
      end
    end
  end

  // Per-sample context held while the engine works.
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      k_r           <= in_data.bend;
      t_r           <= in_data.twist;
      range_r       <= in_range;
      bond_en_r     <= (expected_r != '0);
      last_r        <= is_last;
      chain_fault_r <= fault_r || ({1'b0, in_data.site} != expected_r);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r.total_energy <= eng_sts.total;
      out_data_r.order_error  <= chain_fault_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    eng_sts.done |-> state_r == CS_RUN)
    else $error("engine finished outside the run state");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_EMIT && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("result not loaded on emit");

  a_sample_reads: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> state_r == CS_READ)
    else $error("sample item did not start a memory read");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the chain double-well energy block
// Loads the coefficients of a window of sites, then streams chains of bend and
// twist samples under several register settings and idling patterns. A
// predictor written in fixed point computes each chain total, and a monitor
// checks every result item against the oldest expected total, field by field.
// ----------------------------------------------------------------------------
module tb;
  import cdw_pkg::*;

  localparam int SITES     = 1024;
  localparam int LOADED    = 24;
  localparam int SETTLE    = 64;
  localparam int COEF_SELS = 6;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cdw_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cdw_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  // Idling controls, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state: coefficients, accumulators and registers.
  logic signed [23:0] coef_mem [COEF_SELS][SITES];
  longint             prev_bend;
  longint             bond_acc;
  longint             onsite_acc;
  int unsigned        chain_pos;
  bit                 fault_seen;
  logic [10:0]        reg_chain_length;
  logic signed [23:0] reg_mu;
  logic signed [23:0] reg_alpha;

  cdw_out_t    totals_due [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned totals_seen = 0;
  int unsigned faults_seen = 0;

  chain_double_well_energy dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fixed-point helpers; arithmetic right shift of a signed value is a floor.
  function automatic longint mul_q16(longint x, longint y);
    longint hi;
    longint lo;
    hi = x >>> 16;
    lo = x - hi * 65536;
    return hi * y + ((lo * y) >>> 16);
  endfunction

  function automatic longint clamp48(longint x);
    if (x > SAT_MAX) return SAT_MAX;
    if (x < SAT_MIN) return SAT_MIN;
    return x;
  endfunction

  // On-site energy of one sample with the coefficients of the named site.
  function automatic longint onsite_energy(int unsigned s, longint k, longint t);
    longint q, m, a, b, c, d, k2, m2, t2, diff, quartic, twist_e, tilt_e;
    q = coef_mem[COEF_Q][s];
    m = coef_mem[COEF_M][s];
    a = coef_mem[COEF_A][s];
    b = coef_mem[COEF_B][s];
    c = coef_mem[COEF_C][s];
    d = coef_mem[COEF_D][s];
    k2 = (k * k) >>> 16;
    m2 = (m * m) >>> 16;
    t2 = (t * t) >>> 16;
    diff = k2 - m2;
    quartic = mul_q16((diff * diff) >>> 16, q);
    twist_e = mul_q16(mul_q16(mul_q16(k2, d) + ONE_Q, c), t2) >>> 1;
    tilt_e = mul_q16(mul_q16(mul_q16(k2, b) + ONE_Q, a), t);
    return clamp48(2 * k2 + quartic + twist_e - tilt_e);
  endfunction

  // Update the predicted state for one accepted item and queue any total.
  task automatic predict_item(cdw_in_t it);
    longint   k, t, len;
    cdw_out_t res;
    if (it.operation == OP_WRITE) begin
      if (it.coef_select <= COEF_D) begin
        coef_mem[it.coef_select][it.site] = it.coef_value;
      end
      return;
    end
    k = longint'(it.bend);
    t = longint'(it.twist);
    if (it.site != chain_pos) fault_seen = 1'b1;
    if (chain_pos != 0) begin
      bond_acc = clamp48(bond_acc + 2 * ((prev_bend * k) >>> 16));
    end
    onsite_acc = clamp48(onsite_acc + onsite_energy(it.site, k, t));
    prev_bend = k;
    len = longint'(reg_chain_length);
    if (len == 0) len = 1;
    if (len > SITES) len = SITES;
    if (chain_pos + 1 < len) begin
      chain_pos++;
      return;
    end
    res.total_energy = 48'(clamp48(-mul_q16(bond_acc, TWO_Q + longint'(reg_mu))
                                   + mul_q16(onsite_acc, longint'(reg_alpha))));
    res.order_error = fault_seen;
    totals_due = {totals_due, res};
    prev_bend = 0;
    bond_acc = 0;
    onsite_acc = 0;
    chain_pos = 0;
    fault_seen = 1'b0;
  endtask

  // Send one item with random idle gaps; predict it once it is accepted.
  task automatic send_item(cdw_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  // Random receiver stalls.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result item with the oldest expected total.
  always @(posedge clk) begin
    cdw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (totals_due.size() == 0) begin
        $error("unexpected result item: total_energy %0d", out_data.total_energy);
        errors++;
      end else begin
        want = totals_due.pop_front();
        totals_seen++;
        if (want.order_error) faults_seen++;
        if (out_data.total_energy !== want.total_energy) begin
          $error("total_energy mismatch: expected %0d, actual %0d",
                 want.total_energy, out_data.total_energy);
          errors++;
        end
        if (out_data.order_error !== want.order_error) begin
          $error("order_error mismatch: expected %0d, actual %0d",
                 want.order_error, out_data.order_error);
          errors++;
        end
      end
    end
  end

  // Hold the sender until all totals are in, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_CHAIN_LENGTH) reg_chain_length = value[10:0];
    else if (idx == CFG_NEIGHBOUR_SHIFT) reg_mu = value;
    else if (idx == CFG_ONSITE_SCALE) reg_alpha = value;
  endtask

  task automatic set_regs(logic [10:0] len, logic [23:0] mu, logic [23:0] alpha);
    drain();
    write_reg(CFG_CHAIN_LENGTH, {13'd0, len});
    write_reg(CFG_NEIGHBOUR_SHIFT, mu);
    write_reg(CFG_ONSITE_SCALE, alpha);
  endtask

  // Values are mostly small so totals stay in range; a few span the field.
  function automatic logic [23:0] rand_coef();
    if ($urandom_range(7) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(262143)) - 131072);
  endfunction

  function automatic logic [19:0] rand_q316();
    if ($urandom_range(7) == 0) return 20'($urandom);
    return 20'($signed($urandom_range(262143)) - 131072);
  endfunction

  task automatic send_write(logic [9:0] s, logic [2:0] sel, logic [23:0] v);
    cdw_in_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.site = s;
    it.coef_select = sel;
    it.coef_value = v;
    it.bend = 20'($urandom);
    it.twist = 20'($urandom);
    send_item(it);
  endtask

  task automatic send_sample(logic [9:0] s, logic [19:0] k, logic [19:0] t);
    cdw_in_t it;
    it.operation = OP_SAMPLE;
    it.site = s;
    it.coef_select = 3'($urandom);
    it.coef_value = 24'($urandom);
    it.bend = k;
    it.twist = t;
    send_item(it);
  endtask

  // Every site of the window gets all six coefficients; some sites also see
  // selects 6 and 7, which must be ignored.
  task automatic test_load_coefficients();
    for (int s = 0; s < LOADED; s++) begin
      for (int sel = 0; sel < 8; sel++) begin
        if (sel < COEF_SELS || (s % 4) == 0) begin
          send_write(10'(s), 3'(sel), rand_coef());
        end
      end
    end
  endtask

  // Extreme coefficients, bends and registers drive both saturation limits.
  task automatic test_extremes();
    for (int sel = 0; sel < COEF_SELS; sel++) begin
      send_write(10'd0, 3'(sel), 24'h7FFFFF);
      send_write(10'd1, 3'(sel), 24'h800000);
    end
    set_regs(11'd2, 24'h7FFFFF, 24'h7FFFFF);
    send_sample(10'd0, 20'h7FFFF, 20'h80000);
    send_sample(10'd1, 20'h80000, 20'h7FFFF);
    set_regs(11'd2, 24'h800000, 24'h800000);
    send_sample(10'd0, 20'h80000, 20'h80000);
    send_sample(10'd1, 20'h7FFFF, 20'h7FFFF);
    send_sample(10'd0, 20'h00000, 20'h00000);
    send_sample(10'd1, 20'h7FFFF, 20'h00000);
  endtask

  // One-site chains, set directly and through a length of zero.
  task automatic test_single_site();
    set_regs(11'd1, 24'h010000, 24'h010000);
    send_sample(10'd5, rand_q316(), rand_q316());
    send_sample(10'd0, rand_q316(), rand_q316());
    set_regs(11'd0, 24'hFF0000, 24'h008000);
    send_sample(10'd0, rand_q316(), rand_q316());
    send_sample(10'd3, rand_q316(), rand_q316());
  endtask

  // Out-of-order sites, with a write in the middle of the chain.
  task automatic test_order_error();
    set_regs(11'd3, 24'h000000, 24'h010000);
    send_sample(10'd0, rand_q316(), rand_q316());
    send_write(10'd2, COEF_Q, rand_coef());
    send_sample(10'd2, rand_q316(), rand_q316());
    send_sample(10'd2, rand_q316(), rand_q316());
    send_sample(10'd0, rand_q316(), rand_q316());
    send_sample(10'd1, rand_q316(), rand_q316());
    send_sample(10'd2, rand_q316(), rand_q316());
  endtask

  // One long chain over every loaded site.
  task automatic test_full_chain();
    set_regs(11'(LOADED), 24'($urandom), 24'h010000);
    for (int s = 0; s < LOADED; s++) begin
      send_sample(10'(s), rand_q316(), rand_q316());
    end
  endtask

  // Random chains: mostly in order, with stray writes and misplaced sites.
  task automatic test_random_chains(int unsigned items, int unsigned idle,
                                    int unsigned stall);
    int unsigned done;
    int unsigned len;
    done = 0;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (done < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(LOADED, 1) : $urandom_range(6, 1);
      set_regs(11'(len), ($urandom_range(3) == 0) ? 24'($urandom) : rand_coef(),
               ($urandom_range(3) == 0) ? 24'($urandom) : rand_coef());
      for (int p = 0; p < len; p++) begin
        if ($urandom_range(9) == 0) begin
          send_write(10'($urandom), 3'($urandom), rand_coef());
          done++;
        end
        if ($urandom_range(12) == 0) begin
          send_sample(10'($urandom_range(LOADED - 1)), rand_q316(), rand_q316());
        end else begin
          send_sample(10'(p), rand_q316(), rand_q316());
        end
        done++;
      end
    end
    drain();
  endtask

  // Main sequence.
  initial begin
    prev_bend = 0;
    bond_acc = 0;
    onsite_acc = 0;
    chain_pos = 0;
    fault_seen = 1'b0;
    reg_chain_length = 11'd1024;
    reg_mu = 24'sd0;
    reg_alpha = 24'sd65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_load_coefficients();
    test_extremes();
    test_single_site();
    test_order_error();
    test_full_chain();
    test_random_chains(85, 0, 0);
    test_random_chains(85, 73, 0);
    test_random_chains(85, 0, 73);
    test_random_chains(85, 17, 17);
    $display("Sent %0d items; checked %0d chain totals, %0d with order faults.",
             items_sent, totals_seen, faults_seen);
    $display("Covered saturation, one-site, long and out-of-order chains.");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #6400000;
    $display("tb failed");
    $finish;
  end

endmodule
